/* rtl/slks_pkg.sv */
package slks_pkg;

	localparam int unsigned LineCapacity = 64;
	localparam int unsigned WinDepth = 17;
	localparam int unsigned KwCount = 17;
	localparam int unsigned KwMaxLen = WinDepth + 1;
	localparam int unsigned NumGroups = 7;
	localparam int unsigned CodeW = 3;
	localparam int unsigned ResultSlots = 2;
	localparam int unsigned ResultOccW = $clog2(ResultSlots + 1);
	localparam int unsigned ResultPtrW = $clog2(ResultSlots);

	localparam logic [7:0] CharLf = 8'h0A;
	localparam logic [7:0] CharCr = 8'h0D;
	localparam logic [7:0] CharNul = 8'h00;

	typedef logic [7:0] byte_t;
	typedef logic [CodeW-1:0] cmd_code_t;

	typedef struct packed {
		logic valid;
		cmd_code_t code;
	} result_t;

	// Keyword text, first byte in the top byte lane, padded with zeros below.
	localparam logic [KwMaxLen*8-1:0] KwText [KwCount] = '{
		{144'hE8AFB7_E4BB8B_E7BB8D_E4BDA0_E887AA_E5B7B1},
		{96'hE4BB8B_E7BB8D_E887AA_E5B7B1, 48'h0},
		{96'hE4BDA0_E5A5BD_E5B08F_E889BE, 48'h0},
		{48'hE4BDA0_E5A5BD, 96'h0},
		{96'hE5B08F_E889BE_E5B08F_E889BE, 48'h0},
		{96'hE5B08F_E788B1_E5B08F_E788B1, 48'h0},
		{96'hE5A4A9_E6B094_E5A682_E4BD95, 48'h0},
		{120'hE5A4A9_E6B094_E6808E_E4B988_E6A0B7, 24'h0},
		{48'hE5A4A9_E6B094, 96'h0},
		{120'hE78EB0_E59CA8_E587A0_E782B9_E4BA86, 24'h0},
		{72'hE587A0_E782B9_E4BA86, 72'h0},
		{48'hE697B6_E997B4, 96'h0},
		{96'hE69BB4_E68DA2_E59BBE_E78987, 48'h0},
		{72'hE68DA2_E59BBE_E78987, 72'h0},
		{72'hE68DA2_E8838C_E699AF, 72'h0},
		{48'hE588B7_E696B0, 96'h0},
		{56'h72_65_66_72_65_73_68, 88'h0}
	};

	localparam int unsigned KwLen [KwCount] = '{
		18, 12, 12, 6, 12, 12, 12, 15, 6, 15, 9, 6, 12, 9, 9, 6, 7
	};

	localparam int unsigned KwGroup [KwCount] = '{
		0, 0, 1, 1, 2, 2, 3, 3, 3, 4, 4, 4, 5, 5, 5, 6, 6
	};

endpackage

/* rtl/slks_ifs.sv */
interface slks_rx_if;
	logic valid;
	logic ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface slks_cmd_if;
	logic valid;
	logic ready;
	logic [2:0] command_code;

	modport source (output valid, output command_code, input ready);
	modport sink (input valid, input command_code, output ready);
endinterface

interface slks_cfg_if;
	logic valid;
	logic ready;
	logic receiver_enabled;

	modport source (output valid, output receiver_enabled, input ready);
	modport sink (input valid, input receiver_enabled, output ready);
endinterface

/* rtl/slks_match.sv */
module slks_match #(
	parameter int unsigned LINE_CAPACITY = slks_pkg::LineCapacity
) (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input slks_pkg::byte_t rx_byte,
	input logic enable,
	output logic pending,
	output slks_pkg::result_t result
);

	localparam int unsigned LenW = $clog2(LINE_CAPACITY);

	logic valid_s1;
	slks_pkg::byte_t byte_s1;

	slks_pkg::byte_t window_q [slks_pkg::WinDepth];
	logic [LenW-1:0] len_q;
	logic zero_seen_q;
	logic [slks_pkg::KwCount-1:0] hits_q;

	slks_pkg::byte_t cur [slks_pkg::KwMaxLen];
	logic [slks_pkg::KwCount-1:0] match;
	logic [slks_pkg::NumGroups-1:0] group_hit;
	slks_pkg::cmd_code_t best;
	logic is_lf;
	logic is_cr;
	logic room;
	logic zero_next;
	logic clear_line;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept & enable;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= rx_byte;
		end
	end

	always_comb begin
		cur[0] = byte_s1;
		for (int i = 1; i < slks_pkg::KwMaxLen; i++) begin
			cur[i] = window_q[i-1];
		end
	end

	// Each keyword is compared against the newest bytes, last keyword byte first.
	always_comb begin
		for (int k = 0; k < slks_pkg::KwCount; k++) begin
			match[k] = 1'b1;
			for (int i = 0; i < slks_pkg::KwMaxLen; i++) begin
				if (i < slks_pkg::KwLen[k]) begin
					if (slks_pkg::KwText[k][(slks_pkg::KwMaxLen - slks_pkg::KwLen[k] + i)*8 +: 8]
							!= cur[i]) begin
						match[k] = 1'b0;
					end
				end
			end
		end
	end

	always_comb begin
		group_hit = '0;
		for (int k = 0; k < slks_pkg::KwCount; k++) begin
			group_hit[slks_pkg::KwGroup[k]] = group_hit[slks_pkg::KwGroup[k]] | hits_q[k];
		end
		best = '0;
		for (int g = slks_pkg::NumGroups - 1; g >= 0; g--) begin
			if (group_hit[g]) begin
				best = slks_pkg::CodeW'(g);
			end
		end
	end

	assign is_lf = (byte_s1 == slks_pkg::CharLf);
	assign is_cr = (byte_s1 == slks_pkg::CharCr);
	assign room = (len_q < LenW'(LINE_CAPACITY - 1));
	assign zero_next = zero_seen_q | (byte_s1 == slks_pkg::CharNul);
	assign clear_line = is_lf | (!is_cr & !room);

	assign pending = valid_s1;
	assign result.valid = valid_s1 & is_lf & (|hits_q);
	assign result.code = best;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < slks_pkg::WinDepth; i++) begin
				window_q[i] <= '0;
			end
			len_q <= '0;
			zero_seen_q <= 1'b0;
			hits_q <= '0;
		end else if (valid_s1) begin
			if (clear_line) begin
				for (int i = 0; i < slks_pkg::WinDepth; i++) begin
					window_q[i] <= '0;
				end
				len_q <= '0;
				zero_seen_q <= 1'b0;
				hits_q <= '0;
			end else if (!is_cr) begin
				window_q[0] <= byte_s1;
				for (int i = 1; i < slks_pkg::WinDepth; i++) begin
					window_q[i] <= window_q[i-1];
				end
				len_q <= len_q + 1'b1;
				zero_seen_q <= zero_next;
				if (!zero_next) begin
					hits_q <= hits_q | match;
				end
			end
		end
	end

endmodule

/* rtl/slks_resq.sv */
module slks_resq (
	input logic clk,
	input logic arst_n,
	input slks_pkg::result_t push,
	input logic pop,
	output slks_pkg::cmd_code_t head,
	output logic [slks_pkg::ResultOccW-1:0] count
);

	slks_pkg::cmd_code_t slot_q [slks_pkg::ResultSlots];
	logic [slks_pkg::ResultPtrW-1:0] wr_q;
	logic [slks_pkg::ResultPtrW-1:0] rd_q;
	logic [slks_pkg::ResultOccW-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push.valid) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			count_q <= count_q + slks_pkg::ResultOccW'(push.valid)
				- slks_pkg::ResultOccW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			slot_q[wr_q] <= push.code;
		end
	end

	assign head = slot_q[rd_q];
	assign count = count_q;

endmodule

/* rtl/serial_line_keyword_spotter.sv */
// Channel   Role    Payload            Transaction
// rx        sink    rx_byte[7:0]       one received byte
// cmd       source  command_code[2:0]  one command at the end of a line
// cfg       sink    receiver_enabled   one register write
//
// One byte is taken every cycle; a newline's command is registered in the result queue.
// The byte runs through an input register, the keyword compare and a two-slot result queue.
// Reset clears the line state, the queue and the enable register, with no clearing pass.
// The rx side stalls when queued commands plus the registered input byte fill the queue.
module serial_line_keyword_spotter #(
	parameter int unsigned LINE_CAPACITY = slks_pkg::LineCapacity
) (
	input logic clk,
	input logic arst_n,
	slks_rx_if.sink rx,
	slks_cmd_if.source cmd,
	slks_cfg_if.sink cfg
);

	logic enable_q;
	logic rx_accept;
	logic cmd_pop;
	logic pending;
	slks_pkg::result_t result;
	logic [slks_pkg::ResultOccW-1:0] count;
	logic [slks_pkg::ResultOccW:0] committed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			enable_q <= cfg.receiver_enabled;
		end
	end

	assign cfg.ready = 1'b1;

	assign cmd_pop = cmd.valid & cmd.ready;
	assign committed = {1'b0, count} - (slks_pkg::ResultOccW + 1)'(cmd_pop)
		+ (slks_pkg::ResultOccW + 1)'(pending);
	assign rx.ready = (committed < (slks_pkg::ResultOccW + 1)'(slks_pkg::ResultSlots));
	assign rx_accept = rx.valid & rx.ready;

	slks_match #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_match (
		.clk(clk),
		.arst_n(arst_n),
		.accept(rx_accept),
		.rx_byte(rx.rx_byte),
		.enable(enable_q),
		.pending(pending),
		.result(result)
	);

	slks_resq u_resq (
		.clk(clk),
		.arst_n(arst_n),
		.push(result),
		.pop(cmd_pop),
		.head(cmd.command_code),
		.count(count)
	);

	assign cmd.valid = (count != '0);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> ((count - slks_pkg::ResultOccW'(cmd_pop))
			< slks_pkg::ResultOccW'(slks_pkg::ResultSlots)))
		else $error("Result queue overflow.");

	a_disabled_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(rx_accept && !enable_q) |=> !result.valid)
		else $error("Command produced while the receiver is disabled.");

	a_only_newline: assert property (@(posedge clk) disable iff (!arst_n)
		(rx_accept && rx.rx_byte != slks_pkg::CharLf) |=> !result.valid)
		else $error("Command produced by a byte other than newline.");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid |-> (cmd.command_code < slks_pkg::CodeW'(slks_pkg::NumGroups)))
		else $error("Command code out of range.");

endmodule
